FILE: src/ldrs_pkg.sv
// Shared types, codes and geometry constants for the linear disk read splitter.
package ldrs_pkg;

    // Geometry of the joined disk space
    localparam int BLOCK_BYTES    = 256;
    localparam int DISK_BYTES     = 65536;
    localparam int DISK_COUNT     = 16;
    localparam int MAX_READ_BYTES = 1024;
    localparam int MAX_RESULTS    = 15;
    localparam int MAX_CHUNKS     = MAX_RESULTS / 3;
    localparam int OPCODE_SHIFT   = 12;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 20;
    localparam int LEN_W    = 11;
    localparam int CMD_W    = 20;
    localparam int DISK_W   = 4;
    localparam int BLOCK_W  = 8;
    localparam int FROM_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int TO_W     = 10;
    localparam int STATUS_W = 3;
    localparam int CODE_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam int OFFS_W     = $clog2(BLOCK_BYTES);
    localparam int DISK_SHIFT = $clog2(DISK_BYTES);
    localparam int CHUNK_W    = $clog2(MAX_CHUNKS);
    localparam int SUM_W      = ADDR_W + 1;
    localparam logic [SUM_W-1:0]  SPACE_BYTES = SUM_W'(DISK_BYTES * DISK_COUNT);
    localparam logic [ADDR_W-1:0] DISK_MASK   = ADDR_W'(DISK_BYTES - 1);
    localparam logic [ADDR_W-1:0] OFFS_MASK   = ADDR_W'(BLOCK_BYTES - 1);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_MOUNT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNMOUNT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MOUNT_STATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND_END  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_MOUNTED = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMOUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_DISK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_BLOCK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_BLOCK = 3'd4;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SINGLE,
        S_SEEK_DISK,
        S_SEEK_BLOCK,
        S_READ
    } t_state;

    // How a loaded request is handled
    typedef enum logic [1:0] {
        CLS_IGNORE,
        CLS_SINGLE,
        CLS_CHUNK
    } t_cls;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit_single;
        logic emit_seek_disk;
        logic emit_seek_block;
        logic emit_read;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cls cls;
        logic fin;
        logic out_free;
    } t_dp_status;

endpackage

FILE: src/ldrs_ctrl.sv
// Controller state machine: sequences request evaluation and result beats.
module ldrs_ctrl
    import ldrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                unique case (i_status.cls)
                    CLS_SINGLE: n_state = S_SINGLE;
                    CLS_CHUNK:  n_state = S_SEEK_DISK;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_SINGLE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_SEEK_DISK: begin
                if (i_status.out_free) n_state = S_SEEK_BLOCK;
            end
            S_SEEK_BLOCK: begin
                if (i_status.out_free) n_state = S_READ;
            end
            S_READ: begin
                if (i_status.out_free) n_state = i_status.fin ? S_IDLE : S_SEEK_DISK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs; no request is taken while reset is held
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid & i_rst_n;
            end
            S_SINGLE:     o_cmd.emit_single     = i_status.out_free;
            S_SEEK_DISK:  o_cmd.emit_seek_disk  = i_status.out_free;
            S_SEEK_BLOCK: o_cmd.emit_seek_block = i_status.out_free;
            S_READ:       o_cmd.emit_read       = i_status.out_free;
            default: ;
        endcase
    end

`ifndef SYNTH
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EVAL))
        else $error("accepted request did not enter evaluation");

    a_emit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.emit_single, o_cmd.emit_seek_disk,
                  o_cmd.emit_seek_block, o_cmd.emit_read}))
        else $error("more than one datapath command at once");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_single || o_cmd.emit_seek_disk || o_cmd.emit_seek_block ||
         o_cmd.emit_read) |-> i_status.out_free)
        else $error("result beat issued into an occupied output register");

    a_eval_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_state != S_EVAL))
        else $error("evaluation lasted more than one cycle");
`endif

endmodule

FILE: src/ldrs_dp.sv
// Datapath: opcode registers, mount flag, request and chunk registers, output register.
module ldrs_dp
    import ldrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CODE_W-1:0]     i_cfg_data,
    // request
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [ADDR_W-1:0]     i_start,
    input  logic [LEN_W-1:0]      i_len,
    // control
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    // result
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CMD_W-1:0]      o_cmd_word,
    output logic [DISK_W-1:0]     o_disk,
    output logic [BLOCK_W-1:0]    o_block,
    output logic [FROM_W-1:0]     o_from,
    output logic [COUNT_W-1:0]    o_count,
    output logic [TO_W-1:0]       o_to,
    output logic                  o_issue,
    output logic [STATUS_W-1:0]   o_stat,
    output logic [LEN_W-1:0]      o_retlen,
    output logic                  o_last
);

    logic [CODE_W-1:0]   r_mount_code, r_unmount_code, r_seek_disk_code;
    logic [CODE_W-1:0]   r_seek_block_code, r_read_block_code;
    logic                r_mounted;
    logic [KIND_W-1:0]   r_kind;
    logic [ADDR_W-1:0]   r_addr;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_done;
    logic [CHUNK_W-1:0]  r_chunk;

    logic                r_out_valid;
    logic [CMD_W-1:0]    r_cmd_word;
    logic [DISK_W-1:0]   r_disk;
    logic [BLOCK_W-1:0]  r_block;
    logic [FROM_W-1:0]   r_from;
    logic [COUNT_W-1:0]  r_count;
    logic [TO_W-1:0]     r_to;
    logic                r_issue;
    logic [STATUS_W-1:0] r_stat;
    logic [LEN_W-1:0]    r_retlen;
    logic                r_last;

    logic [CMD_W-1:0]    n_cmd_word;
    logic [DISK_W-1:0]   n_disk;
    logic [BLOCK_W-1:0]  n_block;
    logic [FROM_W-1:0]   n_from;
    logic [COUNT_W-1:0]  n_count;
    logic [TO_W-1:0]     n_to;
    logic                n_issue;
    logic [STATUS_W-1:0] n_stat;
    logic [LEN_W-1:0]    n_retlen;
    logic                n_last;

    logic [SUM_W-1:0]    sum_end;
    logic [CMD_W-1:0]    s_cmd;
    logic                s_issue;
    logic [STATUS_W-1:0] s_status;
    t_cls                cls;
    logic [DISK_W-1:0]   c_disk;
    logic [BLOCK_W-1:0]  c_block;
    logic [FROM_W-1:0]   c_offs;
    logic [COUNT_W-1:0]  c_span;
    logic [LEN_W-1:0]    c_rem;
    logic [COUNT_W-1:0]  c_cnt;
    logic                c_fin;
    logic                emit_any;

    // Opcode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mount_code      <= 8'd0;
            r_unmount_code    <= 8'd1;
            r_seek_disk_code  <= 8'd2;
            r_seek_block_code <= 8'd3;
            r_read_block_code <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MOUNT:      r_mount_code      <= i_cfg_data;
                CFG_UNMOUNT:    r_unmount_code    <= i_cfg_data;
                CFG_SEEK_DISK:  r_seek_disk_code  <= i_cfg_data;
                CFG_SEEK_BLOCK: r_seek_block_code <= i_cfg_data;
                CFG_READ_BLOCK: r_read_block_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Single-result evaluation and request class
    assign sum_end = {1'b0, r_addr} + SUM_W'(r_len);

    always_comb begin
        s_cmd    = '0;
        s_issue  = 1'b0;
        s_status = ST_OK;
        cls      = CLS_IGNORE;
        unique case (r_kind)
            KIND_MOUNT: begin
                cls = CLS_SINGLE;
                if (r_mounted) begin
                    s_status = ST_MOUNT_STATE;
                end else begin
                    s_cmd   = CMD_W'(r_mount_code) << OPCODE_SHIFT;
                    s_issue = 1'b1;
                end
            end
            KIND_UNMOUNT: begin
                cls = CLS_SINGLE;
                if (!r_mounted) begin
                    s_status = ST_MOUNT_STATE;
                end else begin
                    s_cmd   = CMD_W'(r_unmount_code) << OPCODE_SHIFT;
                    s_issue = 1'b1;
                end
            end
            KIND_READ: begin
                cls = CLS_SINGLE;
                if (sum_end > SPACE_BYTES) begin
                    s_status = ST_BEYOND_END;
                end else if (r_len > LEN_W'(MAX_READ_BYTES)) begin
                    s_status = ST_TOO_LONG;
                end else if (!r_mounted) begin
                    s_status = ST_NOT_MOUNTED;
                end else if (r_len != '0) begin
                    cls = CLS_CHUNK;
                end
            end
            default: cls = CLS_IGNORE;
        endcase
    end

    // Current chunk geometry
    assign c_disk  = DISK_W'(r_addr >> DISK_SHIFT);
    assign c_block = BLOCK_W'((r_addr & DISK_MASK) >> OFFS_W);
    assign c_offs  = FROM_W'(r_addr & OFFS_MASK);
    assign c_span  = COUNT_W'(BLOCK_BYTES) - COUNT_W'(c_offs);
    assign c_rem   = r_len - r_done;
    assign c_cnt   = (c_rem < LEN_W'(c_span)) ? COUNT_W'(c_rem) : c_span;
    assign c_fin   = (c_rem <= LEN_W'(c_span)) || (r_chunk == CHUNK_W'(MAX_CHUNKS - 1));

    // Request and chunk progress registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_addr  <= i_start;
            r_len   <= i_len;
            r_done  <= '0;
            r_chunk <= '0;
        end else if (i_cmd.emit_read) begin
            r_addr  <= r_addr + ADDR_W'(c_cnt);
            r_done  <= r_done + LEN_W'(c_cnt);
            r_chunk <= r_chunk + CHUNK_W'(1);
        end
    end

    // Mount flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mounted <= 1'b0;
        end else if (i_cmd.emit_single && s_issue) begin
            r_mounted <= (r_kind == KIND_MOUNT);
        end
    end

    // Output register
    assign emit_any = i_cmd.emit_single | i_cmd.emit_seek_disk |
                      i_cmd.emit_seek_block | i_cmd.emit_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_any) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Next result beat
    always_comb begin
        n_cmd_word = '0;
        n_disk     = '0;
        n_block    = '0;
        n_from     = '0;
        n_count    = '0;
        n_to       = '0;
        n_issue    = 1'b1;
        n_stat     = ST_OK;
        n_retlen   = '0;
        n_last     = 1'b0;
        if (i_cmd.emit_single) begin
            n_cmd_word = s_cmd;
            n_issue    = s_issue;
            n_stat     = s_status;
            n_last     = 1'b1;
        end else begin
            n_disk  = c_disk;
            n_block = c_block;
            if (i_cmd.emit_seek_disk) begin
                n_cmd_word = (CMD_W'(r_seek_disk_code) << OPCODE_SHIFT) |
                             CMD_W'(c_disk);
            end else if (i_cmd.emit_seek_block) begin
                n_cmd_word = (CMD_W'(r_seek_block_code) << OPCODE_SHIFT) |
                             (CMD_W'(c_block) << DISK_W);
            end else begin
                n_cmd_word = (CMD_W'(r_read_block_code) << OPCODE_SHIFT) |
                             (CMD_W'(c_block) << DISK_W) | CMD_W'(c_disk);
                n_from     = c_offs;
                n_count    = c_cnt;
                n_to       = TO_W'(r_done);
                n_retlen   = c_fin ? r_len : '0;
                n_last     = c_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_any) begin
            r_cmd_word <= n_cmd_word;
            r_disk     <= n_disk;
            r_block    <= n_block;
            r_from     <= n_from;
            r_count    <= n_count;
            r_to       <= n_to;
            r_issue    <= n_issue;
            r_stat     <= n_stat;
            r_retlen   <= n_retlen;
            r_last     <= n_last;
        end
    end

    assign o_status.cls      = cls;
    assign o_status.fin      = c_fin;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_cmd_word  = r_cmd_word;
    assign o_disk      = r_disk;
    assign o_block     = r_block;
    assign o_from      = r_from;
    assign o_count     = r_count;
    assign o_to        = r_to;
    assign o_issue     = r_issue;
    assign o_stat      = r_stat;
    assign o_retlen    = r_retlen;
    assign o_last      = r_last;

endmodule

FILE: src/linear_disk_read_splitter_unit.sv
// Top level of the linear disk read splitter: ports, packing and submodule wiring.
//
// Requests enter on the s_axis channel: tuser holds the kind (mount, unmount,
// read), tdata the start address and byte length. Results leave on m_axis as
// device command beats; tlast marks the final beat of each request. Opcodes
// are set through the cfg write channel, which is ready whenever out of reset.
//
// A request is accepted only while the controller is idle. After acceptance
// the request is evaluated once. Mount, unmount, error and empty reads
// produce one beat. A read of N block-bounded chunks produces 3*N beats (at
// most 15); the sequencer emits one beat per cycle into the output register
// while it is free or being emptied. Unknown kinds produce nothing.
//
// While m_axis_tready is low the beat holds in the output register and the
// sequencer waits in place; one beat is buffered, so a new request may be
// accepted while the last beat of the previous one is still pending.
// Reset (synchronous, active low) restores default opcodes, clears the
// mounted flag and drops any pending beat; both input channels hold ready
// low while reset is asserted.
module linear_disk_read_splitter_unit
    import ldrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // start_address[19:0], byte_length[30:20]
    input  logic [KIND_W-1:0]     s_axis_tuser,  // kind[1:0]
    // result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,  // command_word[19:0], disk_number[23:20],
                                                 // block_number[31:24], copy_from[39:32],
                                                 // copy_count[48:40], copy_to[58:49],
                                                 // returned_length[69:59]
    output logic [3:0]            m_axis_tuser,  // issue_command[0], status[3:1]
    output logic                  m_axis_tlast,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CODE_W-1:0]     i_cfg_data
);

    t_dp_cmd             dp_cmd;
    t_dp_status          dp_status;
    logic [CMD_W-1:0]    cmd_word;
    logic [DISK_W-1:0]   disk;
    logic [BLOCK_W-1:0]  block;
    logic [FROM_W-1:0]   from;
    logic [COUNT_W-1:0]  count;
    logic [TO_W-1:0]     to;
    logic                issue;
    logic [STATUS_W-1:0] stat;
    logic [LEN_W-1:0]    retlen;

    assign o_cfg_ready = i_rst_n;

    // Controller
    ldrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Datapath
    ldrs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (s_axis_tuser),
        .i_start     (s_axis_tdata[ADDR_W-1:0]),
        .i_len       (s_axis_tdata[ADDR_W+LEN_W-1:ADDR_W]),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd_word  (cmd_word),
        .o_disk      (disk),
        .o_block     (block),
        .o_from      (from),
        .o_count     (count),
        .o_to        (to),
        .o_issue     (issue),
        .o_stat      (stat),
        .o_retlen    (retlen),
        .o_last      (m_axis_tlast)
    );

    // Result packing, lowest field first
    assign m_axis_tdata = {2'b00, retlen, to, count, from, block, disk, cmd_word};
    assign m_axis_tuser = {stat, issue};

endmodule
